// ===== rtl/nfi_pkg.sv =====
// ----------------------------------------------------------------------------
// nfi_pkg
// Shared widths, limits, codes and the saturating clamp of the Newton
// forward-difference interpolator.
// ----------------------------------------------------------------------------
package nfi_pkg;

  localparam int MAX_POINTS = 8;
  localparam int FRAC_BITS  = 16;

  localparam int DATA_W  = 32;
  localparam int ACC_W   = 48;
  localparam int HALF_W  = 24;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W  = $clog2(MAX_POINTS);
  localparam int MID_W   = DATA_W + 1;
  localparam int DVD_W   = MID_W + FRAC_BITS;
  localparam int QMAG_W  = DVD_W - 1;
  localparam int DVS_W   = MID_W;
  localparam int CLAMP_W = (DVD_W > ACC_W + 1) ? DVD_W : ACC_W + 1;
  localparam int PROD_W  = 4 * HALF_W;
  localparam int PROD_LIM_EXP = 62;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX;
  localparam logic signed [ACC_W-1:0] OUT_MAX =
    {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_EXTRAP    = 3'd1;
  localparam logic [2:0] STATUS_UNEQUAL   = 3'd2;
  localparam logic [2:0] STATUS_TOO_FEW   = 3'd3;
  localparam logic [2:0] STATUS_SATURATED = 3'd4;
  localparam logic [2:0] STATUS_DROPPED   = 3'd5;

  typedef struct packed {
    logic                    sat;
    logic signed [ACC_W-1:0] val;
  } clamp_t;

  function automatic clamp_t clamp_acc(input logic signed [CLAMP_W-1:0] v);
    clamp_t r;
    if (v > CLAMP_W'(ACC_MAX)) begin
      r.sat = 1'b1;
      r.val = ACC_MAX;
    end else if (v < CLAMP_W'(ACC_MIN)) begin
      r.sat = 1'b1;
      r.val = ACC_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/nfi_ram.sv =====
// ----------------------------------------------------------------------------
// nfi_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nfi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/nfi_div.sv =====
// ----------------------------------------------------------------------------
// nfi_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero.
// ----------------------------------------------------------------------------
module nfi_div import nfi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dividend_i,
  input  logic signed [DVS_W-1:0] divisor_i,
  output logic                    done_o,
  output logic signed [DVD_W-1:0] quotient_o
);

  localparam int DCNT_W = $clog2(QMAG_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DVS_W-1:0]  rem_q;
  logic [QMAG_W-1:0] quo_q;
  logic [DVS_W-1:0]  dvs_q;
  logic              neg_q;

  logic [DVD_W-1:0]  dvd_abs;
  logic [DVS_W-1:0]  dvs_abs;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    rem_sub;
  logic              qbit;
  logic [DVD_W-1:0]  q_ext;

  always_comb begin
    dvd_abs = dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
    dvs_abs = divisor_i[DVS_W-1] ? DVS_W'(-divisor_i) : DVS_W'(divisor_i);
    shifted = {rem_q, quo_q[QMAG_W-1]};
    if (shifted >= {1'b0, dvs_q}) begin
      rem_sub = shifted - {1'b0, dvs_q};
      qbit    = 1'b1;
    end else begin
      rem_sub = shifted;
      qbit    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == DCNT_W'(QMAG_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(QMAG_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dvd_abs[QMAG_W-1:0];
      dvs_q <= dvs_abs;
      neg_q <= dividend_i[DVD_W-1] ^ divisor_i[DVS_W-1];
    end else if (busy_q) begin
      rem_q <= rem_sub[DVS_W-1:0];
      quo_q <= {quo_q[QMAG_W-2:0], qbit};
    end
  end

  assign q_ext      = {1'b0, quo_q};
  assign quotient_o = neg_q ? -$signed(q_ext) : $signed(q_ext);
  assign done_o     = done_q;

endmodule

// ===== rtl/nfi_mul.sv =====
// ----------------------------------------------------------------------------
// nfi_mul
// Saturating fixed-point multiplier built from four half-width partial
// products taken over successive cycles.
// ----------------------------------------------------------------------------
module nfi_mul import nfi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ACC_W-1:0] a_i,
  input  logic signed [ACC_W-1:0] b_i,
  output logic                    done_o,
  output logic                    sat_o,
  output logic signed [ACC_W-1:0] product_o
);

  localparam logic [PROD_W-1:0] PROD_LIM = PROD_W'(1) << PROD_LIM_EXP;

  logic                    busy_q;
  logic [2:0]              cnt_q;
  logic                    pv_q;
  logic                    fin_q;
  logic                    done_q;
  logic [2*HALF_W-1:0]     ua_q;
  logic [2*HALF_W-1:0]     ub_q;
  logic                    neg_q;
  logic [2*HALF_W-1:0]     prod_q;
  logic [1:0]              sh_q;
  logic [PROD_W-1:0]       acc_q;
  logic                    sat_q;
  logic signed [ACC_W-1:0] res_q;

  logic [HALF_W-1:0]       pa;
  logic [HALF_W-1:0]       pb;
  logic [PROD_W-1:0]       prod_shifted;
  logic [PROD_W-1:0]       acc_scaled;
  logic                    sat_fin;
  logic [ACC_W-1:0]        mag_fin;

  always_comb begin
    pa = cnt_q[1] ? ua_q[2*HALF_W-1:HALF_W] : ua_q[HALF_W-1:0];
    pb = cnt_q[0] ? ub_q[2*HALF_W-1:HALF_W] : ub_q[HALF_W-1:0];
    case (sh_q)
      2'd0:    prod_shifted = PROD_W'(prod_q);
      2'd1:    prod_shifted = PROD_W'(prod_q) << HALF_W;
      2'd2:    prod_shifted = PROD_W'(prod_q) << (2 * HALF_W);
      default: prod_shifted = '0;
    endcase
    acc_scaled = acc_q >> FRAC_BITS;
    sat_fin    = (acc_q > PROD_LIM) || (acc_scaled > PROD_W'(ACC_MAX));
    mag_fin    = sat_fin ? ACC_MAX : acc_scaled[ACC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      pv_q   <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      fin_q  <= !start_i && busy_q && cnt_q[2];
      done_q <= fin_q;
      pv_q   <= busy_q && !cnt_q[2] && !start_i;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q[2]) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= (2*HALF_W)'(a_i[ACC_W-1] ? ACC_W'(-a_i) : ACC_W'(a_i));
      ub_q  <= (2*HALF_W)'(b_i[ACC_W-1] ? ACC_W'(-b_i) : ACC_W'(b_i));
      neg_q <= a_i[ACC_W-1] ^ b_i[ACC_W-1];
      acc_q <= '0;
    end else begin
      if (busy_q && !cnt_q[2]) begin
        prod_q <= pa * pb;
        sh_q   <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
      end
      if (pv_q) begin
        acc_q <= acc_q + prod_shifted;
      end
      if (fin_q) begin
        sat_q <= sat_fin;
        res_q <= neg_q ? -$signed(mag_fin) : $signed(mag_fin);
      end
    end
  end

  assign done_o    = done_q;
  assign sat_o     = sat_q;
  assign product_o = res_q;

endmodule

// ===== rtl/newton_forward_interpolator.sv =====
// ----------------------------------------------------------------------------
// newton_forward_interpolator
// Newton forward-difference interpolation over class-interval data.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): a load transaction appends one
// class interval unless the set is already full, in which case the row is
// dropped and flagged; the midpoint and frequency go to the point memory. A
// load gives no result; a load after an evaluate starts a new set. An
// evaluate transaction reads the point memory, builds the forward difference
// table in place in the work memory and returns one result on the output
// channel (out_valid_o / out_stall_i).
// An evaluate runs a scan of the points and a check, a division for p, then
// for each order j a difference sweep, two multiplies (one for j=1) and, from
// the second order on, a division by j. Fewer than two points, or unequal or
// zero spacing, returns a zero value without the divisions.
// Only one evaluate is in flight; in_stall_o is high while it runs. A
// finished result waits in the output register while out_stall_i is high,
// and loads are still taken meanwhile.
// Reset clears the point count, the dropped flag and the set flag; memory
// contents are not cleared.
// ----------------------------------------------------------------------------
module newton_forward_interpolator import nfi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     req_type_i,
  input  logic signed [DATA_W-1:0] lower_bound_i,
  input  logic signed [DATA_W-1:0] upper_bound_i,
  input  logic signed [DATA_W-1:0] frequency_i,
  input  logic signed [DATA_W-1:0] query_x_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] interp_value_o,
  output logic [2:0]               status_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CHK, S_PDIV, S_DIFF, S_FSUB,
    S_CMUL, S_CDIV, S_MACC, S_AMUL, S_FIN, S_DONE
  } state_e;

  state_e                  state_q;
  logic [CNT_W-1:0]        point_count_q;
  logic                    rows_dropped_q;
  logic                    set_closed_q;
  logic signed [DATA_W-1:0] xq_q;
  logic signed [DATA_W-1:0] m0_q;
  logic signed [DATA_W-1:0] mlast_q;
  logic signed [DATA_W-1:0] prev_mid_q;
  logic signed [MID_W-1:0]  h_q;
  logic                    uneq_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] p_q;
  logic signed [ACC_W-1:0] c_q;
  logic signed [ACC_W-1:0] d0_q;
  logic signed [ACC_W-1:0] prev_w_q;
  logic                    sat_q;
  logic [ADDR_W-1:0]       j_q;
  logic [ADDR_W-1:0]       addr_q;
  logic                    issue_q;
  logic                    rv_q;
  logic [ADDR_W-1:0]       ridx_q;
  logic signed [DATA_W-1:0] res_value_q;
  logic [2:0]              res_status_q;
  logic                    out_valid_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic [2:0]              out_status_q;

  logic                    in_acc;
  logic [CNT_W-1:0]        eff_cnt;
  logic                    load_full;
  logic [MID_W-1:0]        bound_sum;
  logic                    pt_we;
  logic [2*DATA_W-1:0]     pt_wdata;
  logic [2*DATA_W-1:0]     pt_rdata;
  logic                    wk_we;
  logic [ADDR_W-1:0]       wk_waddr;
  logic [ACC_W-1:0]        wk_wdata;
  logic [ACC_W-1:0]        wk_rdata;
  logic signed [ACC_W-1:0] work_rd;
  logic signed [DATA_W-1:0] mid_rd;
  logic signed [DATA_W-1:0] frq_rd;
  logic signed [MID_W-1:0]  gap;
  logic [ADDR_W-1:0]       nm1;
  logic [ADDR_W-1:0]       nmj;
  logic [ADDR_W-1:0]       last_addr;
  logic [ADDR_W-1:0]       jm1;
  logic signed [CLAMP_W-1:0] jscaled;
  clamp_t                  diff_cl;
  clamp_t                  fsub_cl;
  clamp_t                  pq_cl;
  clamp_t                  sum_cl;
  logic signed [MID_W-1:0]  dx;
  logic                    div_start;
  logic signed [DVD_W-1:0] div_dvd;
  logic signed [DVS_W-1:0] div_dvs;
  logic                    div_done;
  logic signed [DVD_W-1:0] div_quo;
  logic                    mul_start;
  logic signed [ACC_W-1:0] mul_b;
  logic                    mul_done;
  logic                    mul_sat;
  logic signed [ACC_W-1:0] mul_prod;
  logic                    over_hi;
  logic                    over_lo;
  logic                    fin_sat;
  logic signed [DATA_W-1:0] lo_x;
  logic signed [DATA_W-1:0] hi_x;

  always_comb begin
    in_acc    = in_valid_i && (state_q == S_IDLE);
    eff_cnt   = set_closed_q ? '0 : point_count_q;
    load_full = (eff_cnt == CNT_W'(MAX_POINTS));
    bound_sum = MID_W'(lower_bound_i) + MID_W'(upper_bound_i);
    pt_we     = in_acc && (req_type_i == REQ_LOAD) && !load_full;
    pt_wdata  = {bound_sum[MID_W-1:1], frequency_i};

    mid_rd  = $signed(pt_rdata[2*DATA_W-1:DATA_W]);
    frq_rd  = $signed(pt_rdata[DATA_W-1:0]);
    work_rd = $signed(wk_rdata);
    gap     = MID_W'(mid_rd) - MID_W'(prev_mid_q);

    nm1       = ADDR_W'(point_count_q - 1'b1);
    nmj       = ADDR_W'(point_count_q - CNT_W'(j_q));
    last_addr = (state_q == S_SCAN) ? nm1 : nmj;
    jm1       = j_q - 1'b1;
    jscaled   = CLAMP_W'({jm1, {FRAC_BITS{1'b0}}});

    diff_cl = clamp_acc(CLAMP_W'(work_rd) - CLAMP_W'(prev_w_q));
    fsub_cl = clamp_acc(CLAMP_W'(p_q) - jscaled);
    pq_cl   = clamp_acc(CLAMP_W'(div_quo));
    sum_cl  = clamp_acc(CLAMP_W'(acc_q) + CLAMP_W'(mul_prod));

    wk_we    = 1'b0;
    wk_waddr = ridx_q;
    wk_wdata = ACC_W'(frq_rd);
    if (rv_q && state_q == S_SCAN) begin
      wk_we = 1'b1;
    end else if (rv_q && state_q == S_DIFF && ridx_q != '0) begin
      wk_we    = 1'b1;
      wk_waddr = ridx_q - 1'b1;
      wk_wdata = diff_cl.val;
    end

    dx        = MID_W'(xq_q) - MID_W'(m0_q);
    div_start = 1'b0;
    div_dvd   = {dx, {FRAC_BITS{1'b0}}};
    div_dvs   = h_q;
    if (state_q == S_CHK && h_q != '0 && !uneq_q) begin
      div_start = 1'b1;
    end else if (state_q == S_CMUL && mul_done) begin
      div_start = 1'b1;
      div_dvd   = DVD_W'(mul_prod);
      div_dvs   = DVS_W'({1'b0, j_q});
    end

    mul_start = (state_q == S_FSUB) || (state_q == S_MACC);
    mul_b     = (state_q == S_FSUB) ? fsub_cl.val : d0_q;

    over_hi = acc_q > OUT_MAX;
    over_lo = acc_q < OUT_MIN;
    fin_sat = sat_q || over_hi || over_lo;
    lo_x    = (m0_q > mlast_q) ? mlast_q : m0_q;
    hi_x    = (m0_q > mlast_q) ? m0_q : mlast_q;
  end

  nfi_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_POINTS)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (eff_cnt[ADDR_W-1:0]),
    .wdata_i (pt_wdata),
    .raddr_i (addr_q),
    .rdata_o (pt_rdata)
  );

  nfi_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_POINTS)
  ) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (wk_we),
    .waddr_i (wk_waddr),
    .wdata_i (wk_wdata),
    .raddr_i (addr_q),
    .rdata_o (wk_rdata)
  );

  nfi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  nfi_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (c_q),
    .b_i       (mul_b),
    .done_o    (mul_done),
    .sat_o     (mul_sat),
    .product_o (mul_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      point_count_q  <= '0;
      rows_dropped_q <= 1'b0;
      set_closed_q   <= 1'b0;
      issue_q        <= 1'b0;
      rv_q           <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      rv_q <= issue_q;
      if (issue_q) begin
        ridx_q <= addr_q;
        if (addr_q == last_addr) begin
          issue_q <= 1'b0;
        end else begin
          addr_q <= addr_q + 1'b1;
        end
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc && req_type_i == REQ_LOAD) begin
            set_closed_q <= 1'b0;
            if (load_full) begin
              rows_dropped_q <= 1'b1;
              point_count_q  <= eff_cnt;
            end else begin
              rows_dropped_q <= set_closed_q ? 1'b0 : rows_dropped_q;
              point_count_q  <= eff_cnt + 1'b1;
            end
          end else if (in_acc) begin
            set_closed_q <= 1'b1;
            sat_q        <= 1'b0;
            uneq_q       <= 1'b0;
            xq_q         <= query_x_i;
            if (point_count_q < CNT_W'(2)) begin
              res_value_q  <= '0;
              res_status_q <= STATUS_TOO_FEW;
              state_q      <= S_DONE;
            end else begin
              addr_q  <= '0;
              issue_q <= 1'b1;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rv_q) begin
            if (ridx_q == '0) begin
              m0_q  <= mid_rd;
              acc_q <= ACC_W'(frq_rd);
            end else if (ridx_q == ADDR_W'(1)) begin
              h_q <= gap;
            end else if (gap != h_q) begin
              uneq_q <= 1'b1;
            end
            prev_mid_q <= mid_rd;
            mlast_q    <= mid_rd;
            if (ridx_q == nm1) begin
              state_q <= S_CHK;
            end
          end
        end
        S_CHK: begin
          if (h_q == '0 || uneq_q) begin
            res_value_q  <= '0;
            res_status_q <= STATUS_UNEQUAL;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (div_done) begin
            p_q     <= pq_cl.val;
            c_q     <= pq_cl.val;
            sat_q   <= sat_q | pq_cl.sat;
            j_q     <= ADDR_W'(1);
            addr_q  <= '0;
            issue_q <= 1'b1;
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (rv_q) begin
            prev_w_q <= work_rd;
            if (ridx_q != '0) begin
              sat_q <= sat_q | diff_cl.sat;
            end
            if (ridx_q == ADDR_W'(1)) begin
              d0_q <= diff_cl.val;
            end
            if (ridx_q == nmj) begin
              state_q <= (j_q > ADDR_W'(1)) ? S_FSUB : S_MACC;
            end
          end
        end
        S_FSUB: begin
          sat_q   <= sat_q | fsub_cl.sat;
          state_q <= S_CMUL;
        end
        S_CMUL: begin
          if (mul_done) begin
            sat_q   <= sat_q | mul_sat;
            state_q <= S_CDIV;
          end
        end
        S_CDIV: begin
          if (div_done) begin
            c_q     <= div_quo[ACC_W-1:0];
            state_q <= S_MACC;
          end
        end
        S_MACC: begin
          state_q <= S_AMUL;
        end
        S_AMUL: begin
          if (mul_done) begin
            acc_q <= sum_cl.val;
            sat_q <= sat_q | mul_sat | sum_cl.sat;
            if (j_q == nm1) begin
              state_q <= S_FIN;
            end else begin
              j_q     <= j_q + 1'b1;
              addr_q  <= '0;
              issue_q <= 1'b1;
              state_q <= S_DIFF;
            end
          end
        end
        S_FIN: begin
          if (over_hi) begin
            res_value_q <= OUT_MAX[DATA_W-1:0];
          end else if (over_lo) begin
            res_value_q <= OUT_MIN[DATA_W-1:0];
          end else begin
            res_value_q <= acc_q[DATA_W-1:0];
          end
          if (fin_sat) begin
            res_status_q <= STATUS_SATURATED;
          end else if (rows_dropped_q) begin
            res_status_q <= STATUS_DROPPED;
          end else if (xq_q < lo_x || xq_q > hi_x) begin
            res_status_q <= STATUS_EXTRAP;
          end else begin
            res_status_q <= STATUS_OK;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_value_q  <= res_value_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign interp_value_o = out_value_q;
  assign status_o       = out_status_q;

endmodule

// ===== rtl/nfi_checker.sv =====
// ----------------------------------------------------------------------------
// nfi_checker
// Port-level checks of the Newton forward-difference interpolator.
// ----------------------------------------------------------------------------
module nfi_checker import nfi_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     req_type_i,
  input logic signed [DATA_W-1:0] lower_bound_i,
  input logic signed [DATA_W-1:0] upper_bound_i,
  input logic signed [DATA_W-1:0] frequency_i,
  input logic signed [DATA_W-1:0] query_x_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] interp_value_o,
  input logic [2:0]               status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(interp_value_o) && $stable(status_o))
    else $error("stalled result transaction changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_UNEQUAL || status_o == STATUS_TOO_FEW) |->
      interp_value_o == '0)
    else $error("error status with nonzero value");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i == REQ_EVAL |=> in_stall_o)
    else $error("evaluate transaction did not hold off input");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i == REQ_LOAD && !out_valid_o |=>
      !out_valid_o)
    else $error("load transaction produced a result");

endmodule

bind newton_forward_interpolator nfi_checker u_nfi_checker (.*);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Newton forward-difference interpolator. Loads
// and evaluates go through the valid/stall input channel. Each evaluate is
// predicted when it is accepted, and each result is compared with the oldest
// prediction. The directed part covers too few points, unequal and zero
// spacing, dropped rows, saturation, extrapolation and the field extremes.
// The random part sends equally spaced sets with random content, broken sets
// and noise, under three idling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import nfi_pkg::*;

  localparam longint CYCLE_LIMIT = 10_000_000;
  localparam int     DRAIN_CYCLES = 700;
  localparam longint ONE = 64'sd65536;
  localparam longint SAT_LIM = 64'sh7FFF_FFFF_FFFF;
  localparam longint unsigned PROD_LIM = 64'd1 << 62;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [2:0]               status;
  } interp_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     req_type_i = REQ_LOAD;
  logic signed [DATA_W-1:0] lower_bound_i = '0;
  logic signed [DATA_W-1:0] upper_bound_i = '0;
  logic signed [DATA_W-1:0] frequency_i = '0;
  logic signed [DATA_W-1:0] query_x_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] interp_value_o;
  logic [2:0]               status_o;

  // point set mirrored from the loads
  int     set_points;
  bit     set_dropped;
  bit     set_closed;
  longint set_mid[MAX_POINTS];
  longint set_freq[MAX_POINTS];

  interp_result_t expected_results[$];
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_cycles;
  int  errors = 0;
  int  loads_sent;
  int  evals_sent;
  int  results_seen;
  int  status_seen[8];
  longint cycles = 0;

  newton_forward_interpolator u_dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i = 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    interp_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      status_seen[status_o]++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value %h status %0d", $time, interp_value_o,
                 status_o);
      end else begin
        want = expected_results.pop_front();
        if (want.value !== interp_value_o) begin
          errors++;
          $display("%0t: interp_value expected %h actual %h", $time, want.value,
                   interp_value_o);
        end
        if (want.status !== status_o) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
        end
      end
    end
  end

  function automatic longint clamp_wide(input longint v, inout bit sat);
    if (v > SAT_LIM) begin
      sat = 1'b1;
      return SAT_LIM;
    end
    if (v < -SAT_LIM) begin
      sat = 1'b1;
      return -SAT_LIM;
    end
    return v;
  endfunction

  function automatic longint mul_q16(input longint a, input longint b, inout bit sat);
    longint unsigned ua, ub, m;
    bit neg;
    ua = (a < 0) ? longint'(-a) : longint'(a);
    ub = (b < 0) ? longint'(-b) : longint'(b);
    neg = (a < 0) != (b < 0);
    if (ua != 0 && ub > PROD_LIM / ua) begin
      sat = 1'b1;
      m = SAT_LIM;
    end else begin
      m = (ua * ub) >> FRAC_BITS;
      if (m > SAT_LIM) begin
        sat = 1'b1;
        m = SAT_LIM;
      end
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic interp_result_t predict_interp(input longint xq);
    interp_result_t r;
    longint h, p, c, acc, f, lo, hi;
    longint diff[MAX_POINTS];
    bit sat;
    int n;
    r.value = '0;
    sat = 1'b0;
    n = set_points;
    if (n < 2) begin
      r.status = STATUS_TOO_FEW;
      return r;
    end
    h = set_mid[1] - set_mid[0];
    r.status = STATUS_UNEQUAL;
    if (h == 0) return r;
    for (int i = 1; i < n - 1; i++)
      if (set_mid[i+1] - set_mid[i] != h) return r;
    for (int i = 0; i < n; i++) diff[i] = set_freq[i];
    p = clamp_wide(((xq - set_mid[0]) * ONE) / h, sat);
    acc = diff[0];
    c = p;
    for (int j = 1; j < n; j++) begin
      for (int i = 0; i < n - j; i++) diff[i] = clamp_wide(diff[i+1] - diff[i], sat);
      if (j > 1) begin
        f = clamp_wide(p - longint'(j - 1) * ONE, sat);
        c = mul_q16(c, f, sat) / j;
      end
      acc = clamp_wide(acc + mul_q16(c, diff[0], sat), sat);
    end
    if (acc > 64'sd2147483647) begin
      sat = 1'b1;
      acc = 64'sd2147483647;
    end
    if (acc < -64'sd2147483648) begin
      sat = 1'b1;
      acc = -64'sd2147483648;
    end
    r.value = acc[DATA_W-1:0];
    lo = set_mid[0];
    hi = set_mid[n-1];
    if (lo > hi) begin
      f = lo;
      lo = hi;
      hi = f;
    end
    if (sat) r.status = STATUS_SATURATED;
    else if (set_dropped) r.status = STATUS_DROPPED;
    else if (xq < lo || xq > hi) r.status = STATUS_EXTRAP;
    else r.status = STATUS_OK;
    return r;
  endfunction

  // called and returning just after a falling edge
  task automatic send_item(input logic req, input longint lo, input longint hi,
                           input longint fr, input longint qx);
    longint s;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    req_type_i    = req;
    lower_bound_i = lo[DATA_W-1:0];
    upper_bound_i = hi[DATA_W-1:0];
    frequency_i   = fr[DATA_W-1:0];
    query_x_i     = qx[DATA_W-1:0];
    do @(posedge clk_i); while (in_stall_o);
    if (req == REQ_LOAD) begin
      loads_sent++;
      if (set_closed) begin
        set_points = 0;
        set_dropped = 1'b0;
        set_closed = 1'b0;
      end
      if (set_points >= MAX_POINTS) begin
        set_dropped = 1'b1;
      end else begin
        s = longint'(lower_bound_i) + longint'(upper_bound_i);
        set_mid[set_points] = s >>> 1;
        set_freq[set_points] = longint'(frequency_i);
        set_points++;
      end
    end else begin
      evals_sent++;
      expected_results.push_back(predict_interp(longint'(query_x_i)));
      set_closed = 1'b1;
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_load(input longint lo, input longint hi, input longint fr);
    send_item(REQ_LOAD, lo, hi, fr, $signed($urandom));
  endtask

  task automatic send_eval(input longint qx);
    send_item(REQ_EVAL, $signed($urandom), $signed($urandom), $signed($urandom), qx);
  endtask

  task automatic wait_idle();
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // one equally spaced set; corrupt bends one midpoint
  task automatic send_set(input int n, input longint x0, input longint h,
                          input longint fmag, input bit corrupt);
    longint mid, w;
    for (int i = 0; i < n; i++) begin
      mid = x0 + i * h;
      if (corrupt && i == n - 1) mid += 1;
      w = $urandom_range(0, 65536);
      send_load(mid - w, mid + w + $urandom_range(0, 1),
                longint'($signed($urandom_range(0, 2 * fmag))) - fmag);
    end
  endtask

  task automatic test_too_few();
    send_eval(0);
    send_load(ONE, ONE, 5 * ONE);
    send_eval(ONE);
    send_load(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
    send_eval(-64'sd2147483648);
    wait_idle();
  endtask

  task automatic test_spacing();
    send_set(4, 0, ONE, ONE, 1'b1);
    send_eval(ONE);
    send_set(3, ONE, 0, ONE, 1'b0);
    send_eval(ONE);
    wait_idle();
  endtask

  task automatic test_interpolation();
    send_set(5, 0, ONE, 4 * ONE, 1'b0);
    send_eval(ONE + ONE / 2);
    send_set(8, 10 * ONE, -ONE, 64'sd2147483647, 1'b0);
    send_eval(7 * ONE);
    send_load(64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
    send_load(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
    send_eval(64'sd2147483647);
    send_set(3, 0, 1, ONE, 1'b0);
    send_eval(-64'sd2147483648);
    send_set(2, 0, ONE, ONE, 1'b0);
    send_eval(5 * ONE);
    wait_idle();
  endtask

  task automatic test_dropped_rows();
    send_set(10, -ONE, ONE / 4, ONE, 1'b0);
    send_eval(0);
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    for (int k = 0; k < 4; k++) begin
      send_set(3, 0, ONE, ONE, 1'b0);
      send_eval(ONE / 3);
    end
    wait_idle();
  endtask

  task automatic test_random(input int items);
    int start, n;
    longint x0, h, span, qx;
    start = loads_sent + evals_sent;
    while (loads_sent + evals_sent - start < items) begin
      case ($urandom_range(9))
        0: send_load($signed($urandom), $signed($urandom), $signed($urandom));
        1: send_eval($signed($urandom));
        default: begin
          n = ($urandom_range(9) == 0) ? $urandom_range(0, 10) : $urandom_range(2, 8);
          x0 = longint'($urandom_range(0, 1 << 24)) - (1 << 23);
          h = longint'($urandom_range(1, 1 << ($urandom_range(2, 20))));
          if ($urandom_range(1)) h = -h;
          send_set(n, x0, h, longint'(1) << $urandom_range(4, 30), $urandom_range(11) == 0);
          span = (n + 2) * (h < 0 ? -h : h);
          qx = x0 + (h < 0 ? -1 : 1) * (longint'($urandom_range(0, span)) - span / (n + 1));
          send_eval(qx);
        end
      endcase
    end
  endtask

  initial begin
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_idle_pct = 38;
    recv_idle_pct = 76;
    test_too_few();
    test_spacing();
    test_interpolation();
    test_dropped_rows();
    test_backpressure();
    test_random(600);
    send_idle_pct = 76;
    recv_idle_pct = 38;
    test_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(600);
    wait_idle();
    $display("covered %0d loads and %0d evaluates, %0d results checked", loads_sent,
             evals_sent, results_seen);
    $display("status counts ok %0d extrap %0d unequal %0d few %0d sat %0d dropped %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nfi_pkg.sv
rtl/nfi_ram.sv
rtl/nfi_div.sv
rtl/nfi_mul.sv
rtl/newton_forward_interpolator.sv
rtl/nfi_checker.sv
bench/tb.sv
